### sv/sab_pkg.sv
// Shared constants, codes, sideband type and blend helper for the scaled alpha blit.
// No dependencies; used by sab_div_pipe and scaled_alpha_blit_pixel.
package sab_pkg;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SRC_IDX_W  = 25;
  localparam int unsigned DST_IDX_W  = 20;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned SUM_W      = 16;

  localparam int unsigned DIV_N_W    = COORD_W + DIM_W;
  localparam int unsigned DIV_BPS    = 2;
  localparam int unsigned DIV_STAGES = (DIV_N_W + DIV_BPS - 1) / DIV_BPS;
  localparam int unsigned DIV_PAD_W  = DIV_STAGES * DIV_BPS;

  localparam int unsigned SURFACE_WIDTH_DEF  = 1024;
  localparam int unsigned SURFACE_HEIGHT_DEF = 768;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ORIGIN_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ORIGIN_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT   = 3'd7;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [SUM_W-1:0]  RECIP_255    = 16'h8081;
  localparam int unsigned       RECIP_SHIFT  = 23;

  typedef struct packed {
    logic [DST_IDX_W-1:0] dest_index;
    logic                 clipped;
    logic                 write_enable;
    logic [PIX_W-1:0]     pixel;
  } side_t;

  // exact divide by 255 for 16-bit sums up to 255*255
  function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] sum);
    logic [2*SUM_W-1:0] prod;
    prod = (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP_255);
    return prod[RECIP_SHIFT +: CHAN_W];
  endfunction

endpackage

### sv/sab_div_pipe.sv
// Pipelined restoring divider, DIV_BPS quotient bits per register stage.
// Depends on sab_pkg.
module sab_div_pipe (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [sab_pkg::DIV_N_W-1:0] dividend_i,
  input  logic [sab_pkg::DIM_W-1:0]   divisor_i,
  output logic [sab_pkg::DIV_N_W-1:0] quotient_o
);
  import sab_pkg::*;

  logic [DIM_W-1:0]     rem_q [DIV_STAGES];
  logic [DIV_PAD_W-1:0] nq_q  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIM_W-1:0]     rem_in;
    logic [DIM_W-1:0]     rem_d;
    logic [DIV_PAD_W-1:0] nq_in;
    logic [DIV_PAD_W-1:0] nq_d;
    logic [DIM_W:0]       trial;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = DIV_PAD_W'(dividend_i);
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
    end

    always_comb begin
      rem_d = rem_in;
      nq_d  = nq_in;
      trial = '0;
      for (int b = 0; b < DIV_BPS; b++) begin
        trial = {rem_d, nq_d[DIV_PAD_W-1]};
        nq_d  = {nq_d[DIV_PAD_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor_i}) begin
          trial   = trial - {1'b0, divisor_i};
          nq_d[0] = 1'b1;
        end
        rem_d = trial[DIM_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        nq_q[s]  <= nq_d;
      end
    end
  end

  assign quotient_o = nq_q[DIV_STAGES-1][DIV_N_W-1:0];

endmodule

### sv/scaled_alpha_blit_pixel.sv
// Scaled alpha blit, one destination pixel per word: indices, clip and blend.
// Depends on sab_pkg and sab_div_pipe.
//
//   channel  handshake                  payload
//   cfg      cfg_we_i                   cfg_index_i, cfg_data_i
//   in       in_valid_i / in_ready_o    col_offset_i, row_offset_i, source/dest pixel
//   out      out_valid_o / out_ready_i  source/dest index, clipped, write enable, pixel
//
// One word per cycle sustained while the output is not stalled; words pass through stage A,
// the DIV_STAGES stages of the two pipelined scaling dividers, stage C and the output stage.
// Reset clears config registers to their defaults and all stage valid bits.
// A stalled output freezes every stage; nothing is dropped or repeated.
module scaled_alpha_blit_pixel #(
  parameter int unsigned SURFACE_WIDTH  = sab_pkg::SURFACE_WIDTH_DEF,
  parameter int unsigned SURFACE_HEIGHT = sab_pkg::SURFACE_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sab_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sab_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sab_pkg::COORD_W-1:0]   col_offset_i,
  input  logic [sab_pkg::COORD_W-1:0]   row_offset_i,
  input  logic [sab_pkg::PIX_W-1:0]     source_pixel_i,
  input  logic [sab_pkg::PIX_W-1:0]     dest_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sab_pkg::SRC_IDX_W-1:0] source_index_o,
  output logic [sab_pkg::DST_IDX_W-1:0] dest_index_o,
  output logic                          clipped_o,
  output logic                          write_enable_o,
  output logic [sab_pkg::PIX_W-1:0]     blended_pixel_o
);
  import sab_pkg::*;

  localparam int unsigned DIDX_W = 2 * DIM_W;

  logic [COORD_W-1:0] src_origin_x_q, src_origin_y_q, dst_origin_x_q, dst_origin_y_q;
  logic [DIM_W-1:0]   src_width_q, src_height_q, dst_width_q, dst_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_origin_x_q <= '0;
      src_origin_y_q <= '0;
      src_width_q    <= DIM_W'(1);
      src_height_q   <= DIM_W'(1);
      dst_origin_x_q <= '0;
      dst_origin_y_q <= '0;
      dst_width_q    <= DIM_W'(1);
      dst_height_q   <= DIM_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SRC_ORIGIN_X: src_origin_x_q <= cfg_data_i[COORD_W-1:0];
        CFG_SRC_ORIGIN_Y: src_origin_y_q <= cfg_data_i[COORD_W-1:0];
        CFG_SRC_WIDTH:    src_width_q    <= cfg_data_i;
        CFG_SRC_HEIGHT:   src_height_q   <= cfg_data_i;
        CFG_DST_ORIGIN_X: dst_origin_x_q <= cfg_data_i[COORD_W-1:0];
        CFG_DST_ORIGIN_Y: dst_origin_y_q <= cfg_data_i[COORD_W-1:0];
        CFG_DST_WIDTH:    dst_width_q    <= cfg_data_i;
        CFG_DST_HEIGHT:   dst_height_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_vld_q;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // stage A: products, clip, destination index, blend sums
  logic [DIM_W-1:0]     dx, dy;
  logic [DIDX_W-1:0]    didx_full;
  logic                 clip, in_rect, we;
  logic [CHAN_W-1:0]    alpha, inv_alpha;
  logic [SUM_W-1:0]     sum_r, sum_g, sum_b;

  always_comb begin
    dx        = DIM_W'(dst_origin_x_q) + DIM_W'(col_offset_i);
    dy        = DIM_W'(dst_origin_y_q) + DIM_W'(row_offset_i);
    clip      = (dx >= DIM_W'(SURFACE_WIDTH)) || (dy >= DIM_W'(SURFACE_HEIGHT));
    in_rect   = (DIM_W'(col_offset_i) < dst_width_q) && (DIM_W'(row_offset_i) < dst_height_q);
    didx_full = DIDX_W'(dy) * DIDX_W'(SURFACE_WIDTH) + DIDX_W'(dx);
    alpha     = source_pixel_i[31:24];
    inv_alpha = ALPHA_OPAQUE - alpha;
    we        = !clip && in_rect && (alpha != '0);
    sum_r = SUM_W'(source_pixel_i[23:16]) * SUM_W'(alpha)
          + SUM_W'(dest_pixel_i[23:16]) * SUM_W'(inv_alpha);
    sum_g = SUM_W'(source_pixel_i[15:8]) * SUM_W'(alpha)
          + SUM_W'(dest_pixel_i[15:8]) * SUM_W'(inv_alpha);
    sum_b = SUM_W'(source_pixel_i[7:0]) * SUM_W'(alpha)
          + SUM_W'(dest_pixel_i[7:0]) * SUM_W'(inv_alpha);
  end

  logic                 a_vld_q;
  logic [DIV_N_W-1:0]   a_prod_x_q, a_prod_y_q;
  logic [DST_IDX_W-1:0] a_didx_q;
  logic                 a_clip_q, a_we_q, a_copy_q;
  logic [PIX_W-1:0]     a_sp_q;
  logic [SUM_W-1:0]     a_sum_r_q, a_sum_g_q, a_sum_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_prod_x_q <= DIV_N_W'(col_offset_i) * DIV_N_W'(src_width_q);
      a_prod_y_q <= DIV_N_W'(row_offset_i) * DIV_N_W'(src_height_q);
      a_didx_q   <= clip ? '0 : didx_full[DST_IDX_W-1:0];
      a_clip_q   <= clip;
      a_we_q     <= we;
      a_copy_q   <= (alpha == ALPHA_OPAQUE);
      a_sp_q     <= source_pixel_i;
      a_sum_r_q  <= sum_r;
      a_sum_g_q  <= sum_g;
      a_sum_b_q  <= sum_b;
    end
  end

  // divider stages, sideband delayed alongside
  logic [DIV_N_W-1:0] quot_x, quot_y;

  sab_div_pipe u_div_x (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (a_prod_x_q),
    .divisor_i  (dst_width_q),
    .quotient_o (quot_x)
  );

  sab_div_pipe u_div_y (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (a_prod_y_q),
    .divisor_i  (dst_height_q),
    .quotient_o (quot_y)
  );

  side_t                 side0_d;
  side_t                 side_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] side_vld_q;

  always_comb begin
    side0_d.dest_index   = a_didx_q;
    side0_d.clipped      = a_clip_q;
    side0_d.write_enable = a_we_q;
    if (!a_we_q) begin
      side0_d.pixel = '0;
    end else if (a_copy_q) begin
      side0_d.pixel = a_sp_q;
    end else begin
      side0_d.pixel = {ALPHA_OPAQUE, div255(a_sum_r_q), div255(a_sum_g_q), div255(a_sum_b_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_vld_q <= '0;
    end else if (adv) begin
      side_vld_q <= {side_vld_q[DIV_STAGES-2:0], a_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side0_d;
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // stage C: add source origins
  logic                 c_vld_q;
  logic [SRC_IDX_W-1:0] c_sx_q, c_sy_q;
  side_t                c_side_q;
  logic [SRC_IDX_W-1:0] qx, qy;

  assign qx = (dst_width_q == '0)  ? '0 : quot_x;
  assign qy = (dst_height_q == '0) ? '0 : quot_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= side_vld_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_sx_q   <= SRC_IDX_W'(src_origin_x_q) + qx;
      c_sy_q   <= SRC_IDX_W'(src_origin_y_q) + qy;
      c_side_q <= side_q[DIV_STAGES-1];
    end
  end

  // output stage: row times stride plus column
  logic [SRC_IDX_W+DIM_W-1:0] sidx_prod;
  logic [SRC_IDX_W-1:0]       sidx;
  logic [SRC_IDX_W-1:0]       out_sidx_q;
  side_t                      out_side_q;

  assign sidx_prod = (SRC_IDX_W+DIM_W)'(c_sy_q) * (SRC_IDX_W+DIM_W)'(src_width_q);
  assign sidx      = sidx_prod[SRC_IDX_W-1:0] + c_sx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_sidx_q <= sidx;
      out_side_q <= c_side_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign source_index_o  = out_sidx_q;
  assign dest_index_o    = out_side_q.dest_index;
  assign clipped_o       = out_side_q.clipped;
  assign write_enable_o  = out_side_q.write_enable;
  assign blended_pixel_o = out_side_q.pixel;

  a_no_write_zero_pix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> blended_pixel_o == '0)
    else $error("pixel nonzero without write enable");

  a_clip_kills_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> dest_index_o == '0 && !write_enable_o)
    else $error("clipped word has index or write enable");

  a_written_opaque : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |-> blended_pixel_o[31:24] == ALPHA_OPAQUE)
    else $error("written pixel not opaque");

endmodule
